>>> hdl/ptpm_pkg.sv
// Shared types and constants of the pulse timing pattern matcher.
package ptpm_pkg;

	localparam int STAMP_W   = 32;
	localparam int INDEX_W   = 6;
	localparam int POS_W     = 6;
	localparam int LEN_W     = 7;
	localparam int COOL_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_START  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN       = 2'd2;

	localparam logic [POS_W-1:0]  START_RESET    = 6'd0;
	localparam logic [LEN_W-1:0]  LENGTH_RESET   = 7'd64;
	localparam logic [COOL_W-1:0] COOLDOWN_RESET = 32'd1000000;
	localparam logic [LEN_W-1:0]  MIN_LENGTH     = 7'd2;

	localparam logic REQ_EDGE  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	typedef enum logic {
		KIND_EDGE  = 1'b0,
		KIND_WRITE = 1'b1
	} kind_e_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_EVAL = 1'b1
	} bk_state_t;

	typedef struct packed {
		logic [POS_W-1:0]  start;
		logic [LEN_W-1:0]  length;
		logic [COOL_W-1:0] cooldown;
	} cfg_t;

	typedef struct packed {
		logic             matched;
		logic             trigger;
		logic [POS_W-1:0] position;
	} res_t;

endpackage

>>> hdl/ptpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ptpm_ram #(
	parameter int WIDTH = 44,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/ptpm_front.sv
// Front end: accepts items, drops repeated levels, times edges, prepares pattern bounds.
module ptpm_front #(
	parameter int PATTERN_DEPTH  = 64,
	parameter int TIME_WIDTH     = 32,
	parameter int DURATION_WIDTH = 21,
	localparam int AW = $clog2(PATTERN_DEPTH),
	localparam int HW = DURATION_WIDTH + 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             req_type,
	input  logic                             line_level,
	input  logic [ptpm_pkg::STAMP_W-1:0]     timestamp_us,
	input  logic [ptpm_pkg::INDEX_W-1:0]     entry_index,
	input  logic signed [DURATION_WIDTH-1:0] entry_duration,
	input  logic                             q_ready,
	output logic                             push,
	output ptpm_pkg::kind_e_t                kind,
	output logic [TIME_WIDTH-1:0]            now,
	output logic [TIME_WIDTH-1:0]            delay,
	output logic [AW-1:0]                    addr,
	output logic [HW-1:0]                    lo,
	output logic [HW-1:0]                    hi
);

	logic                      prev_level_q;
	logic [TIME_WIDTH-1:0]     last_edge_q;
	logic                      accept;
	logic                      is_write;
	logic                      index_ok;
	logic                      level_change;
	logic [DURATION_WIDTH-1:0] dur_raw;
	logic [DURATION_WIDTH-1:0] mag;
	logic [DURATION_WIDTH-1:0] quarter;

	assign in_ready     = q_ready;
	assign accept       = in_valid && q_ready;
	assign is_write     = (req_type == ptpm_pkg::REQ_WRITE);
	assign index_ok     = (int'(entry_index) < PATTERN_DEPTH);
	assign level_change = (line_level != prev_level_q);

	// Repeated levels and out-of-range writes are dropped here.
	assign push = accept && (is_write ? index_ok : level_change);
	assign kind = is_write ? ptpm_pkg::KIND_WRITE : ptpm_pkg::KIND_EDGE;

	assign now   = TIME_WIDTH'(timestamp_us);
	assign delay = now - last_edge_q;
	assign addr  = AW'(entry_index);

	// Magnitude of the most negative duration still fits unsigned.
	assign dur_raw = entry_duration;
	assign mag     = dur_raw[DURATION_WIDTH-1] ? (~dur_raw + 1'b1) : dur_raw;
	assign quarter = mag >> 2;
	assign lo      = HW'(mag - quarter);
	assign hi      = HW'(mag) + HW'(quarter);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b0;
			last_edge_q  <= '0;
		end else if (accept && !is_write && level_change) begin
			prev_level_q <= line_level;
			last_edge_q  <= now;
		end
	end

endmodule

>>> hdl/ptpm_queue.sv
// Short flip-flop queue between the front end and the matcher.
module ptpm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             ready,
	output logic             valid,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign ready   = (count_q != CW'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_push = push && ready;
	assign do_pop  = pop && valid;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (rd_ptr_q == wr_ptr_q))
		else $error("empty queue with pointers apart");

endmodule

>>> hdl/ptpm_back.sv
// Matcher: stores pattern bounds, walks the pattern position, issues results.
module ptpm_back #(
	parameter int PATTERN_DEPTH  = 64,
	parameter int TIME_WIDTH     = 32,
	parameter int DURATION_WIDTH = 21,
	localparam int AW = $clog2(PATTERN_DEPTH),
	localparam int HW = DURATION_WIDTH + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  ptpm_pkg::kind_e_t     q_kind,
	input  logic [TIME_WIDTH-1:0] q_now,
	input  logic [TIME_WIDTH-1:0] q_delay,
	input  logic [AW-1:0]         q_addr,
	input  logic [HW-1:0]         q_lo,
	input  logic [HW-1:0]         q_hi,
	input  ptpm_pkg::cfg_t        cfg,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ptpm_pkg::res_t        res
);

	localparam int CW = (TIME_WIDTH > HW) ? TIME_WIDTH : HW;
	localparam int KW = (TIME_WIDTH > ptpm_pkg::COOL_W) ? TIME_WIDTH : ptpm_pkg::COOL_W;
	localparam int LW = ptpm_pkg::LEN_W;
	localparam int PSW = ptpm_pkg::POS_W;

	ptpm_pkg::bk_state_t   state_q;
	ptpm_pkg::bk_state_t   state_d;
	logic [PSW-1:0]        pos_q;
	logic [TIME_WIDTH-1:0] last_match_q;
	logic                  out_valid_q;
	ptpm_pkg::res_t        res_q;
	logic [TIME_WIDTH-1:0] now_s2;
	logic [TIME_WIDTH-1:0] delay_s2;

	logic                  out_free;
	logic                  ram_we;
	logic                  ram_re;
	logic                  finish;
	logic [2*HW-1:0]       ram_rdata;
	logic                  pos_in_range;
	logic [HW-1:0]         exp_lo;
	logic [HW-1:0]         exp_hi;
	logic                  miss;
	logic [LW-1:0]         len_c;
	logic [LW-1:0]         len_m1;
	logic [LW-1:0]         pos_inc;
	logic                  matched;
	logic [TIME_WIDTH-1:0] since_match;
	logic                  trigger;
	logic [PSW-1:0]        pos_next;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptpm_pkg::BK_IDLE: begin
				if (q_valid && q_kind == ptpm_pkg::KIND_EDGE) begin
					state_d = ptpm_pkg::BK_EVAL;
				end
			end
			ptpm_pkg::BK_EVAL: begin
				if (out_free) begin
					state_d = ptpm_pkg::BK_IDLE;
				end
			end
			default: state_d = ptpm_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop  = 1'b0;
		ram_we = 1'b0;
		ram_re = 1'b0;
		finish = 1'b0;
		unique case (state_q)
			ptpm_pkg::BK_IDLE: begin
				q_pop  = q_valid;
				ram_we = q_valid && (q_kind == ptpm_pkg::KIND_WRITE);
				ram_re = q_valid && (q_kind == ptpm_pkg::KIND_EDGE);
			end
			ptpm_pkg::BK_EVAL: begin
				finish = out_free;
			end
			default: ;
		endcase
	end

	ptpm_ram #(
		.WIDTH(2 * HW),
		.DEPTH(PATTERN_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(q_addr),
		.wdata({q_lo, q_hi}),
		.re   (ram_re),
		.raddr(AW'(pos_q)),
		.rdata(ram_rdata)
	);

	// Positions past the store read as a zero duration.
	assign pos_in_range = (int'(pos_q) < PATTERN_DEPTH);
	assign exp_lo = pos_in_range ? ram_rdata[2*HW-1:HW] : '0;
	assign exp_hi = pos_in_range ? ram_rdata[HW-1:0] : '0;
	assign miss   = (CW'(delay_s2) > CW'(exp_hi)) || (CW'(delay_s2) < CW'(exp_lo));

	// Clamp length to the store depth and to at least two.
	always_comb begin
		len_c = cfg.length;
		if (int'(cfg.length) > PATTERN_DEPTH) begin
			len_c = LW'(PATTERN_DEPTH);
		end
		if (len_c < ptpm_pkg::MIN_LENGTH) begin
			len_c = ptpm_pkg::MIN_LENGTH;
		end
	end

	assign len_m1      = len_c - 1'b1;
	assign pos_inc     = LW'(pos_q) + 1'b1;
	assign matched     = !miss && (pos_inc >= len_m1);
	assign since_match = now_s2 - last_match_q;
	assign trigger     = matched && (KW'(since_match) >= KW'(cfg.cooldown));
	assign pos_next    = (miss || matched) ? cfg.start : pos_inc[PSW-1:0];

	always_ff @(posedge clk) begin
		if (ram_re) begin
			now_s2   <= q_now;
			delay_s2 <= q_delay;
		end
		if (finish) begin
			res_q.matched  <= matched;
			res_q.trigger  <= trigger;
			res_q.position <= pos_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ptpm_pkg::BK_IDLE;
			pos_q        <= '0;
			last_match_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				pos_q <= pos_next;
				if (matched) begin
					last_match_q <= now_s2;
				end
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	a_read_then_eval: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> (state_q == ptpm_pkg::BK_EVAL))
		else $error("pattern read not followed by evaluation");

	a_result_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ptpm_pkg::BK_EVAL))
		else $error("result raised outside evaluation");

	a_trigger_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.trigger) |-> res_q.matched)
		else $error("transmit trigger without a match");

endmodule

>>> hdl/pulse_timing_pattern_matcher.sv
// Pulse timing pattern matcher top level: configuration registers, front end, queue, matcher.
// Edge items compare the time since the last level change with the stored pattern
// duration (within one quarter) and step the pattern position; pattern-write items load
// the pattern memory, and edge items at an unchanged level are dropped without a result.
// The input takes an item every cycle while the two-entry queue has room. A finished
// result waits in an output register, and the next edge's evaluation stalls until it is
// taken. In the matcher a pattern write is handled while idle; an edge goes through the
// registered read of the pattern memory at the current position, then the bound compare and
// position update, and no further item is taken meanwhile. The pattern memory needs no
// clearing after reset; write every entry the pattern uses before sending edges.
module pulse_timing_pattern_matcher #(
	parameter int PATTERN_DEPTH  = 64,
	parameter int TIME_WIDTH     = 32,
	parameter int DURATION_WIDTH = 21
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [ptpm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ptpm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                req_type,
	input  logic                                line_level,
	input  logic [ptpm_pkg::STAMP_W-1:0]        timestamp_us,
	input  logic [ptpm_pkg::INDEX_W-1:0]        entry_index,
	input  logic signed [DURATION_WIDTH-1:0]    entry_duration,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                sequence_matched,
	output logic                                trigger_transmit,
	output logic [ptpm_pkg::POS_W-1:0]          position
);

	localparam int AW = $clog2(PATTERN_DEPTH);
	localparam int HW = DURATION_WIDTH + 1;
	localparam int QW = 1 + 2 * TIME_WIDTH + AW + 2 * HW;

	ptpm_pkg::cfg_t        cfg_q;
	ptpm_pkg::res_t        res;

	logic                  fe_push;
	ptpm_pkg::kind_e_t     fe_kind;
	logic [TIME_WIDTH-1:0] fe_now;
	logic [TIME_WIDTH-1:0] fe_delay;
	logic [AW-1:0]         fe_addr;
	logic [HW-1:0]         fe_lo;
	logic [HW-1:0]         fe_hi;

	logic                  q_ready;
	logic                  q_valid;
	logic                  q_pop;
	logic [QW-1:0]         q_wdata;
	logic [QW-1:0]         q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start    <= ptpm_pkg::START_RESET;
			cfg_q.length   <= ptpm_pkg::LENGTH_RESET;
			cfg_q.cooldown <= ptpm_pkg::COOLDOWN_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ptpm_pkg::CFG_PATTERN_START:  cfg_q.start    <= cfg_data[ptpm_pkg::POS_W-1:0];
				ptpm_pkg::CFG_PATTERN_LENGTH: cfg_q.length   <= cfg_data[ptpm_pkg::LEN_W-1:0];
				ptpm_pkg::CFG_COOLDOWN:       cfg_q.cooldown <= cfg_data[ptpm_pkg::COOL_W-1:0];
				default: ;
			endcase
		end
	end

	ptpm_front #(
		.PATTERN_DEPTH (PATTERN_DEPTH),
		.TIME_WIDTH    (TIME_WIDTH),
		.DURATION_WIDTH(DURATION_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.line_level    (line_level),
		.timestamp_us  (timestamp_us),
		.entry_index   (entry_index),
		.entry_duration(entry_duration),
		.q_ready       (q_ready),
		.push          (fe_push),
		.kind          (fe_kind),
		.now           (fe_now),
		.delay         (fe_delay),
		.addr          (fe_addr),
		.lo            (fe_lo),
		.hi            (fe_hi)
	);

	assign q_wdata = {fe_kind, fe_now, fe_delay, fe_addr, fe_lo, fe_hi};

	ptpm_queue #(
		.WIDTH(QW),
		.DEPTH(ptpm_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fe_push),
		.wdata (q_wdata),
		.ready (q_ready),
		.valid (q_valid),
		.pop   (q_pop),
		.rdata (q_rdata)
	);

	ptpm_back #(
		.PATTERN_DEPTH (PATTERN_DEPTH),
		.TIME_WIDTH    (TIME_WIDTH),
		.DURATION_WIDTH(DURATION_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_kind   (ptpm_pkg::kind_e_t'(q_rdata[QW-1])),
		.q_now    (q_rdata[QW-2 -: TIME_WIDTH]),
		.q_delay  (q_rdata[QW-2-TIME_WIDTH -: TIME_WIDTH]),
		.q_addr   (q_rdata[2*HW +: AW]),
		.q_lo     (q_rdata[HW +: HW]),
		.q_hi     (q_rdata[0 +: HW]),
		.cfg      (cfg_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res      (res)
	);

	assign sequence_matched = res.matched;
	assign trigger_transmit = res.trigger;
	assign position         = res.position;

endmodule
